### rtl/core/crdr_pkg.sv
// Shared types, constants and tables of the cursor driven point rotator.
`timescale 1ns / 1ps
`default_nettype none

package crdr_pkg;

  // Field widths.
  localparam int unsigned OP_W      = 2;
  localparam int unsigned CUR_W     = 16;
  localparam int unsigned PT_W      = 32;
  localparam int unsigned ANG_W     = 16;
  localparam int unsigned COEF_W    = 16;
  localparam int unsigned CENTRE_W  = 15;
  localparam int unsigned CFG_IDX_W = 2;

  // Fixed-point setup.
  localparam int unsigned FRAC_BITS    = 12;
  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned ATAN_ENTRIES = 24;
  localparam int unsigned STEP_W       = 5;
  localparam int unsigned PRESCALE     = 12;
  localparam int unsigned Q14_SHIFT    = 14;

  // Internal datapath widths.
  localparam int unsigned DIFF_W    = CUR_W + 1;
  localparam int unsigned CR_W      = 34;
  localparam int unsigned BASE_W    = CUR_W + FRAC_BITS;
  localparam int unsigned REL_W     = PT_W + 2;
  localparam int unsigned ACC_W     = REL_W + COEF_W + 1;
  localparam int unsigned SUM_W     = ACC_W - Q14_SHIFT + 1;
  localparam int unsigned MAC_CNT_W = 4;

  localparam logic signed [CR_W-1:0]   INV_GAIN  = CR_W'(163008219);
  localparam logic signed [CR_W-1:0]   HALF_TURN = CR_W'(64'sd2147483648);
  localparam logic signed [COEF_W-1:0] COEF_ONE  = COEF_W'(16384);
  localparam logic signed [ANG_W:0]    QUARTER   = (ANG_W+1)'(16384);
  localparam logic signed [ANG_W:0]    HALF_ANG  = (ANG_W+1)'(32768);

  // Item kinds carried in tuser.
  typedef enum logic [OP_W-1:0] {
    OP_BEGIN  = 2'd0,
    OP_CURSOR = 2'd1,
    OP_POINT  = 2'd2
  } op_e;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MODE     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTRE_X = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTRE_Y = 2'd2;

  typedef enum logic [2:0] {
    TS_IDLE,
    TS_VEC_NEW,
    TS_VEC_OLD,
    TS_ROT,
    TS_MAC,
    TS_OUT
  } top_state_e;

  typedef enum logic {
    CS_IDLE,
    CS_RUN
  } cord_state_e;

  typedef enum logic [1:0] {
    MS_IDLE,
    MS_RUN,
    MS_RND,
    MS_FIN
  } mac_state_e;

  // Command word from the sequencer to the CORDIC unit.
  typedef struct packed {
    logic                     start;
    logic                     vectoring;
    logic signed [DIFF_W-1:0] x;
    logic signed [DIFF_W-1:0] y;
    logic [ANG_W-1:0]         ang;
  } cord_cmd_t;

  // Result word of the CORDIC unit.
  typedef struct packed {
    logic                     done;
    logic [ANG_W-1:0]         angle;
    logic signed [COEF_W-1:0] cosine;
    logic signed [COEF_W-1:0] sine;
  } cord_res_t;

  // Arctangent of 2^-i in 2^-32 turns.
  function automatic logic [31:0] atan_lut(input logic [STEP_W-1:0] idx);
    logic [31:0] r;
    case (idx)
      5'd0:  r = 32'h20000000;
      5'd1:  r = 32'h12E4051E;
      5'd2:  r = 32'h09FB385B;
      5'd3:  r = 32'h051111D4;
      5'd4:  r = 32'h028B0D43;
      5'd5:  r = 32'h0145D7E1;
      5'd6:  r = 32'h00A2F61E;
      5'd7:  r = 32'h00517C55;
      5'd8:  r = 32'h0028BE53;
      5'd9:  r = 32'h00145F2F;
      5'd10: r = 32'h000A2F98;
      5'd11: r = 32'h000517CC;
      5'd12: r = 32'h00028BE6;
      5'd13: r = 32'h000145F3;
      5'd14: r = 32'h0000A2FA;
      5'd15: r = 32'h0000517D;
      5'd16: r = 32'h000028BE;
      5'd17: r = 32'h0000145F;
      5'd18: r = 32'h00000A30;
      5'd19: r = 32'h00000518;
      5'd20: r = 32'h0000028C;
      5'd21: r = 32'h00000146;
      5'd22: r = 32'h000000A3;
      5'd23: r = 32'h00000051;
      default: r = 32'h0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/core/crdr_cordic.sv
// Iterative CORDIC unit: vectoring (atan2) and rotating (sine and cosine), one step per cycle.
`timescale 1ns / 1ps
`default_nettype none

module crdr_cordic (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  crdr_pkg::cord_cmd_t  cmd_i,
  output crdr_pkg::cord_res_t  res_o
);

  localparam int unsigned CW = crdr_pkg::CR_W;

  crdr_pkg::cord_state_e state_q, state_d;
  logic                  vec_q, vec_d;
  logic                  flip_q, flip_d;
  logic                  done_q, done_d;
  logic signed [CW-1:0]  x_q, x_d, y_q, y_d, z_q, z_d;
  logic [crdr_pkg::STEP_W-1:0] i_q, i_d;

  logic signed [crdr_pkg::DIFF_W-1:0] ax, ay;
  logic signed [crdr_pkg::ANG_W:0]    a_raw, a_adj;
  logic                               a_flip;
  logic signed [CW-1:0]  shx, shy, atan_v;
  logic                  ccw;
  logic [31:0]           ang_sum;

  // Rounds a Q5.28 value to Q1.14 and clamps it to plus or minus one.
  function automatic logic signed [crdr_pkg::COEF_W-1:0] to_q14(
    input logic signed [CW-1:0] v, input logic neg);
    logic signed [CW-1:0] r;
    logic signed [CW-1:0] lim;
    logic signed [crdr_pkg::COEF_W-1:0] c;
    lim = CW'(crdr_pkg::COEF_ONE);
    r = (v + CW'(8192)) >>> crdr_pkg::Q14_SHIFT;
    if (r > lim) begin
      r = lim;
    end else if (r < -lim) begin
      r = -lim;
    end
    c = r[crdr_pkg::COEF_W-1:0];
    return neg ? -c : c;
  endfunction

  // Folding of the angle into the right half plane.
  always_comb begin
    a_raw  = (crdr_pkg::ANG_W+1)'($signed(cmd_i.ang));
    a_adj  = a_raw;
    a_flip = 1'b0;
    if (a_raw > crdr_pkg::QUARTER) begin
      a_adj  = a_raw - crdr_pkg::HALF_ANG;
      a_flip = 1'b1;
    end else if (a_raw < -crdr_pkg::QUARTER) begin
      a_adj  = a_raw + crdr_pkg::HALF_ANG;
      a_flip = 1'b1;
    end
    ax = (cmd_i.x < 0) ? -cmd_i.x : cmd_i.x;
    ay = (cmd_i.x < 0) ? -cmd_i.y : cmd_i.y;
  end

  // One micro-rotation per cycle.
  always_comb begin
    shx    = x_q >>> i_q;
    shy    = y_q >>> i_q;
    atan_v = CW'(crdr_pkg::atan_lut(i_q));
    ccw    = vec_q ? !(y_q > 0) : (z_q >= 0);

    state_d = state_q;
    vec_d   = vec_q;
    flip_d  = flip_q;
    x_d     = x_q;
    y_d     = y_q;
    z_d     = z_q;
    i_d     = i_q;
    done_d  = 1'b0;

    case (state_q)
      crdr_pkg::CS_IDLE: begin
        if (cmd_i.start) begin
          vec_d = cmd_i.vectoring;
          i_d   = '0;
          if (cmd_i.vectoring) begin
            flip_d = 1'b0;
            x_d    = CW'(ax) <<< crdr_pkg::PRESCALE;
            y_d    = CW'(ay) <<< crdr_pkg::PRESCALE;
            z_d    = (cmd_i.x < 0) ? crdr_pkg::HALF_TURN : '0;
            if (cmd_i.x == 0 && cmd_i.y == 0) begin
              // A zero vector has angle zero.
              z_d    = '0;
              done_d = 1'b1;
            end else begin
              state_d = crdr_pkg::CS_RUN;
            end
          end else begin
            flip_d  = a_flip;
            x_d     = crdr_pkg::INV_GAIN;
            y_d     = '0;
            z_d     = CW'(a_adj) <<< 16;
            state_d = crdr_pkg::CS_RUN;
          end
        end
      end
      crdr_pkg::CS_RUN: begin
        if (ccw) begin
          x_d = x_q - shy;
          y_d = y_q + shx;
          z_d = z_q - atan_v;
        end else begin
          x_d = x_q + shy;
          y_d = y_q - shx;
          z_d = z_q + atan_v;
        end
        i_d = i_q + 1'b1;
        if (i_q == crdr_pkg::STEP_W'(crdr_pkg::CORDIC_STEPS - 1)) begin
          state_d = crdr_pkg::CS_IDLE;
          done_d  = 1'b1;
        end
      end
      default: state_d = crdr_pkg::CS_IDLE;
    endcase
  end

  // Control and datapath registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= crdr_pkg::CS_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    vec_q  <= vec_d;
    flip_q <= flip_d;
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    i_q    <= i_d;
  end

  // Results, valid in the cycle of the done pulse.
  assign ang_sum      = z_q[31:0] + 32'd32768;
  assign res_o.done   = done_q;
  assign res_o.angle  = ang_sum[31:16];
  assign res_o.cosine = to_q14(x_q, flip_q);
  assign res_o.sine   = to_q14(y_q, flip_q);

endmodule

`default_nettype wire

### rtl/core/crdr_mac.sv
// Bit-serial point rotator: multiplies by cosine and sine one coefficient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none

module crdr_mac (
  input  wire                                      clk_i,
  input  wire                                      rst_ni,
  input  wire                                      start_i,
  input  wire signed [crdr_pkg::PT_W-1:0]          point_x_i,
  input  wire signed [crdr_pkg::PT_W-1:0]          point_y_i,
  input  wire signed [crdr_pkg::CUR_W-1:0]         pivot_x_i,
  input  wire signed [crdr_pkg::CUR_W-1:0]         pivot_y_i,
  input  wire signed [crdr_pkg::COEF_W-1:0]        cos_i,
  input  wire signed [crdr_pkg::COEF_W-1:0]        sin_i,
  output logic                                     done_o,
  output logic signed [crdr_pkg::PT_W-1:0]         rot_x_o,
  output logic signed [crdr_pkg::PT_W-1:0]         rot_y_o
);

  localparam int unsigned AW = crdr_pkg::ACC_W;
  localparam int unsigned SW = crdr_pkg::SUM_W;

  crdr_pkg::mac_state_e state_q, state_d;
  logic [crdr_pkg::MAC_CNT_W-1:0] cnt_q, cnt_d;
  logic                           done_q, done_d;
  logic signed [crdr_pkg::REL_W-1:0]  relx_q, relx_d, rely_q, rely_d;
  logic signed [crdr_pkg::BASE_W-1:0] bx_q, bx_d, by_q, by_d;
  logic [crdr_pkg::COEF_W-1:0]        cq_q, cq_d, sq_q, sq_d;
  logic signed [AW-1:0]               accx_q, accx_d, accy_q, accy_d;
  logic signed [crdr_pkg::PT_W-1:0]   rx_q, rx_d, ry_q, ry_d;

  logic signed [crdr_pkg::BASE_W-1:0] bx_in, by_in;
  logic signed [AW-1:0]               ex, ey, tx, ty;
  logic                               cb, sb;

  // Clamps a widened sum to the signed 32-bit range.
  function automatic logic signed [crdr_pkg::PT_W-1:0] sat_pt(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] hi, lo;
    logic signed [crdr_pkg::PT_W-1:0] r;
    hi = SW'({1'b0, {(crdr_pkg::PT_W-1){1'b1}}});
    lo = -hi - SW'(1);
    if (v > hi) begin
      r = hi[crdr_pkg::PT_W-1:0];
    end else if (v < lo) begin
      r = lo[crdr_pkg::PT_W-1:0];
    end else begin
      r = v[crdr_pkg::PT_W-1:0];
    end
    return r;
  endfunction

  // Pivot in point format.
  assign bx_in = crdr_pkg::BASE_W'(pivot_x_i) <<< crdr_pkg::FRAC_BITS;
  assign by_in = crdr_pkg::BASE_W'(pivot_y_i) <<< crdr_pkg::FRAC_BITS;

  always_comb begin
    cb = cq_q[crdr_pkg::COEF_W-1];
    sb = sq_q[crdr_pkg::COEF_W-1];
    ex = AW'(relx_q);
    ey = AW'(rely_q);
    tx = (cb ? ex : '0) - (sb ? ey : '0);
    ty = (sb ? ex : '0) + (cb ? ey : '0);

    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    relx_d  = relx_q;
    rely_d  = rely_q;
    bx_d    = bx_q;
    by_d    = by_q;
    cq_d    = cq_q;
    sq_d    = sq_q;
    accx_d  = accx_q;
    accy_d  = accy_q;
    rx_d    = rx_q;
    ry_d    = ry_q;

    case (state_q)
      crdr_pkg::MS_IDLE: begin
        if (start_i) begin
          relx_d  = crdr_pkg::REL_W'(point_x_i) - crdr_pkg::REL_W'(bx_in);
          rely_d  = crdr_pkg::REL_W'(point_y_i) - crdr_pkg::REL_W'(by_in);
          bx_d    = bx_in;
          by_d    = by_in;
          cq_d    = cos_i;
          sq_d    = sin_i;
          cnt_d   = '0;
          state_d = crdr_pkg::MS_RUN;
        end
      end
      crdr_pkg::MS_RUN: begin
        // Most significant coefficient bit first; its weight is negative.
        if (cnt_q == '0) begin
          accx_d = -tx;
          accy_d = -ty;
        end else begin
          accx_d = (accx_q <<< 1) + tx;
          accy_d = (accy_q <<< 1) + ty;
        end
        cq_d  = cq_q << 1;
        sq_d  = sq_q << 1;
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == crdr_pkg::MAC_CNT_W'(crdr_pkg::COEF_W - 1)) begin
          state_d = crdr_pkg::MS_RND;
        end
      end
      crdr_pkg::MS_RND: begin
        accx_d  = accx_q + AW'(8192);
        accy_d  = accy_q + AW'(8192);
        state_d = crdr_pkg::MS_FIN;
      end
      crdr_pkg::MS_FIN: begin
        rx_d    = sat_pt(SW'(accx_q >>> crdr_pkg::Q14_SHIFT) + SW'(bx_q));
        ry_d    = sat_pt(SW'(accy_q >>> crdr_pkg::Q14_SHIFT) + SW'(by_q));
        done_d  = 1'b1;
        state_d = crdr_pkg::MS_IDLE;
      end
      default: state_d = crdr_pkg::MS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= crdr_pkg::MS_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q  <= cnt_d;
    relx_q <= relx_d;
    rely_q <= rely_d;
    bx_q   <= bx_d;
    by_q   <= by_d;
    cq_q   <= cq_d;
    sq_q   <= sq_d;
    accx_q <= accx_d;
    accy_q <= accy_d;
    rx_q   <= rx_d;
    ry_q   <= ry_d;
  end

  assign done_o  = done_q;
  assign rot_x_o = rx_q;
  assign rot_y_o = ry_q;

endmodule

`default_nettype wire

### rtl/core/cursor_driven_point_rotator.sv
// Top level of the cursor driven point rotator: item sequencer, state and output register.
//
//   channel  direction  handshake                  word
//   s_axis   in         s_axis_tvalid/tready       tuser opcode; tdata cursor and point
//   m_axis   out        m_axis_tvalid/tready       tdata rotated point
//   cfg      in         cfg_valid_i/cfg_ready_o    register index and data
//
// A begin word leaves the input ready again on the next cycle. Each pass of the shared
// 16-step CORDIC unit runs command register, load and steps (none for a zero vector), so
// a cursor word holds the input for two passes in mode 1 and three in mode 0. A point
// word holds it for load, 16 multiplier steps, rounding, saturation, handoff and output
// load, longer while the output register is still full; a result then waits there while
// the next word is taken. Reset clears the control state at once; the config port is always ready.
`timescale 1ns / 1ps
`default_nettype none

module cursor_driven_point_rotator (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  wire  [95:0]                           s_axis_tdata,  // cursor_x, cursor_y, point_x, point_y
  input  wire  [crdr_pkg::OP_W-1:0]             s_axis_tuser,  // opcode
  output logic                                  m_axis_tvalid,
  input  wire                                   m_axis_tready,
  output logic [63:0]                           m_axis_tdata,  // rotated_x, rotated_y
  input  wire                                   cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire  [crdr_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  wire  [crdr_pkg::CENTRE_W-1:0]         cfg_data_i
);

  localparam int unsigned CW = crdr_pkg::CUR_W;
  localparam int unsigned DW = crdr_pkg::DIFF_W;

  crdr_pkg::top_state_e state_q, state_d;
  logic                            mode_q, mode_d;
  logic [crdr_pkg::CENTRE_W-1:0]   cx_cfg_q, cx_cfg_d, cy_cfg_q, cy_cfg_d;
  logic signed [CW-1:0]            pivot_x_q, pivot_x_d, pivot_y_q, pivot_y_d;
  logic signed [CW-1:0]            old_x_q, old_x_d, old_y_q, old_y_d;
  logic signed [CW-1:0]            cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [crdr_pkg::ANG_W-1:0]      prev_q, prev_d, t1_q, t1_d;
  logic signed [crdr_pkg::COEF_W-1:0] cos_q, cos_d, sin_q, sin_d;
  crdr_pkg::cord_cmd_t             cmd_q, cmd_d;
  logic                            mac_start_q, mac_start_d;
  logic                            out_valid_q, out_valid_d;
  logic [63:0]                     out_data_q, out_data_d;
  logic signed [crdr_pkg::PT_W-1:0] in_px_q, in_py_q;

  crdr_pkg::cord_res_t             cres;
  logic                            mac_done;
  logic signed [crdr_pkg::PT_W-1:0] rot_x, rot_y;

  logic signed [CW-1:0]            in_cx, in_cy;
  logic [crdr_pkg::PT_W-1:0]       in_px, in_py;
  logic                            in_acc;

  assign in_cx  = s_axis_tdata[15:0];
  assign in_cy  = s_axis_tdata[31:16];
  assign in_px  = s_axis_tdata[63:32];
  assign in_py  = s_axis_tdata[95:64];
  assign s_axis_tready = (state_q == crdr_pkg::TS_IDLE);
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o = 1'b1;

  crdr_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_q),
    .res_o  (cres)
  );

  crdr_mac u_mac (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mac_start_q),
    .point_x_i (in_px_q),
    .point_y_i (in_py_q),
    .pivot_x_i (pivot_x_q),
    .pivot_y_i (pivot_y_q),
    .cos_i     (cos_q),
    .sin_i     (sin_q),
    .done_o    (mac_done),
    .rot_x_o   (rot_x),
    .rot_y_o   (rot_y)
  );

  // Point operands held for the multiplier start.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_px_q <= in_px;
      in_py_q <= in_py;
    end
  end

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    mode_d      = mode_q;
    cx_cfg_d    = cx_cfg_q;
    cy_cfg_d    = cy_cfg_q;
    pivot_x_d   = pivot_x_q;
    pivot_y_d   = pivot_y_q;
    old_x_d     = old_x_q;
    old_y_d     = old_y_q;
    cur_x_d     = cur_x_q;
    cur_y_d     = cur_y_q;
    prev_d      = prev_q;
    t1_d        = t1_q;
    cos_d       = cos_q;
    sin_d       = sin_q;
    cmd_d       = cmd_q;
    cmd_d.start = 1'b0;
    mac_start_d = 1'b0;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q && !m_axis_tready;

    // Configuration writes.
    if (cfg_valid_i) begin
      case (cfg_index_i)
        crdr_pkg::REG_MODE:     mode_d   = cfg_data_i[0];
        crdr_pkg::REG_CENTRE_X: cx_cfg_d = cfg_data_i;
        crdr_pkg::REG_CENTRE_Y: cy_cfg_d = cfg_data_i;
        default: ;
      endcase
    end

    case (state_q)
      crdr_pkg::TS_IDLE: begin
        if (in_acc) begin
          case (s_axis_tuser)
            crdr_pkg::OP_BEGIN: begin
              pivot_x_d = mode_q ? in_cx : CW'({1'b0, cx_cfg_q});
              pivot_y_d = mode_q ? in_cy : CW'({1'b0, cy_cfg_q});
              prev_d    = '0;
            end
            crdr_pkg::OP_CURSOR: begin
              cur_x_d         = in_cx;
              cur_y_d         = in_cy;
              cmd_d.start     = 1'b1;
              cmd_d.vectoring = 1'b1;
              cmd_d.x         = DW'(in_cx) - DW'(pivot_x_q);
              cmd_d.y         = DW'(in_cy) - DW'(pivot_y_q);
              state_d         = crdr_pkg::TS_VEC_NEW;
            end
            crdr_pkg::OP_POINT: begin
              mac_start_d = 1'b1;
              state_d     = crdr_pkg::TS_MAC;
            end
            default: ;
          endcase
        end
      end
      crdr_pkg::TS_VEC_NEW: begin
        if (cres.done) begin
          t1_d = cres.angle;
          if (mode_q) begin
            cmd_d.start     = 1'b1;
            cmd_d.vectoring = 1'b0;
            cmd_d.ang       = cres.angle - prev_q;
            prev_d          = cres.angle;
            state_d         = crdr_pkg::TS_ROT;
          end else begin
            cmd_d.start     = 1'b1;
            cmd_d.vectoring = 1'b1;
            cmd_d.x         = DW'(old_x_q) - DW'(pivot_x_q);
            cmd_d.y         = DW'(old_y_q) - DW'(pivot_y_q);
            state_d         = crdr_pkg::TS_VEC_OLD;
          end
        end
      end
      crdr_pkg::TS_VEC_OLD: begin
        if (cres.done) begin
          cmd_d.start     = 1'b1;
          cmd_d.vectoring = 1'b0;
          cmd_d.ang       = t1_q - cres.angle;
          state_d         = crdr_pkg::TS_ROT;
        end
      end
      crdr_pkg::TS_ROT: begin
        if (cres.done) begin
          cos_d   = cres.cosine;
          sin_d   = cres.sine;
          old_x_d = cur_x_q;
          old_y_d = cur_y_q;
          state_d = crdr_pkg::TS_IDLE;
        end
      end
      crdr_pkg::TS_MAC: begin
        if (mac_done) begin
          state_d = crdr_pkg::TS_OUT;
        end
      end
      crdr_pkg::TS_OUT: begin
        // Load the output word once the previous one is gone.
        if (!out_valid_q || m_axis_tready) begin
          out_data_d  = {rot_y, rot_x};
          out_valid_d = 1'b1;
          state_d     = crdr_pkg::TS_IDLE;
        end
      end
      default: state_d = crdr_pkg::TS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= crdr_pkg::TS_IDLE;
      mode_q      <= 1'b0;
      cx_cfg_q    <= crdr_pkg::CENTRE_W'(960);
      cy_cfg_q    <= crdr_pkg::CENTRE_W'(540);
      pivot_x_q   <= '0;
      pivot_y_q   <= '0;
      old_x_q     <= '0;
      old_y_q     <= '0;
      prev_q      <= '0;
      cos_q       <= crdr_pkg::COEF_ONE;
      sin_q       <= '0;
      cmd_q       <= '0;
      mac_start_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mode_q      <= mode_d;
      cx_cfg_q    <= cx_cfg_d;
      cy_cfg_q    <= cy_cfg_d;
      pivot_x_q   <= pivot_x_d;
      pivot_y_q   <= pivot_y_d;
      old_x_q     <= old_x_d;
      old_y_q     <= old_y_d;
      prev_q      <= prev_d;
      cos_q       <= cos_d;
      sin_q       <= sin_d;
      cmd_q       <= cmd_d;
      mac_start_q <= mac_start_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_x_q    <= cur_x_d;
    cur_y_q    <= cur_y_d;
    t1_q       <= t1_d;
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire
